/* design/lkv_pkg.sv */
// ============================================================================
// lkv_pkg: shared types and constants of the LRU key-value cache
// Field widths, action codes, the capacity register layout and the operation
// flags that pass between the top level and the age update logic.
// ============================================================================
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic hit;     // key found: touch the matching entry
    logic insert;  // put of a new key: age every valid entry, new entry is youngest
  } lkv_op_t;

endpackage

/* design/lkv_match.sv */
// ============================================================================
// lkv_match: parallel lookup over the entry store
// Compares the key against every entry and produces one-hot vectors for the
// matching entry, the least recent entry and the lowest free slot.
// ============================================================================
module lkv_match import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int AGE_W       = 4,
  parameter int OCC_W       = 5
) (
  input  logic [KEY_W-1:0]                    key,
  input  logic [MAX_ENTRIES-1:0][KEY_W-1:0]   entry_key,
  input  logic [MAX_ENTRIES-1:0]              entry_valid,
  input  logic [MAX_ENTRIES-1:0][AGE_W-1:0]   entry_age,
  input  logic [OCC_W-1:0]                    occupancy,
  output logic [MAX_ENTRIES-1:0]              match_oh,
  output logic [MAX_ENTRIES-1:0]              victim_oh,
  output logic [MAX_ENTRIES-1:0]              free_oh
);

  logic [OCC_W-1:0]       occ_m1;
  logic [AGE_W-1:0]       oldest_age;
  logic [MAX_ENTRIES-1:0] free_vec;

  // Ages of the valid entries are always a permutation of 0..occupancy-1, so
  // the least recent entry is the one whose age equals occupancy-1.
  assign occ_m1     = occupancy - OCC_W'(1);
  assign oldest_age = AGE_W'(occ_m1);
  assign free_vec   = ~entry_valid;
  assign free_oh    = free_vec & (~free_vec + MAX_ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_oh[i]  = entry_valid[i] && (entry_key[i] == key);
      victim_oh[i] = entry_valid[i] && (entry_age[i] == oldest_age);
    end
  end

endmodule

/* design/lkv_ages.sv */
// ============================================================================
// lkv_ages: next recency ages of all entries
// A hit moves the matching entry to age zero and ages the younger ones; an
// insert ages every valid entry and gives the new slot age zero.
// ============================================================================
module lkv_ages import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int AGE_W       = 4
) (
  input  lkv_op_t                             op,
  input  logic [MAX_ENTRIES-1:0]              entry_valid,
  input  logic [MAX_ENTRIES-1:0][AGE_W-1:0]   entry_age,
  input  logic [MAX_ENTRIES-1:0]              match_oh,
  input  logic [MAX_ENTRIES-1:0]              slot_oh,
  output logic [MAX_ENTRIES-1:0][AGE_W-1:0]   age_nxt
);

  logic [AGE_W-1:0] hit_age;

  always_comb begin
    hit_age = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_age = hit_age | (entry_age[i] & {AGE_W{match_oh[i]}});
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_nxt[i] = entry_age[i];
      if (op.hit) begin
        if (match_oh[i]) begin
          age_nxt[i] = '0;
        end else if (entry_valid[i] && (entry_age[i] < hit_age)) begin
          age_nxt[i] = entry_age[i] + AGE_W'(1);
        end
      end else if (op.insert) begin
        if (slot_oh[i]) begin
          age_nxt[i] = '0;
        end else if (entry_valid[i]) begin
          age_nxt[i] = entry_age[i] + AGE_W'(1);
        end
      end
    end
  end

endmodule

/* design/lru_key_value_cache.sv */
// ============================================================================
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Gets return the stored value on a hit; puts update or insert, evicting the
// least recent entry once occupancy reaches the configured capacity.
// ============================================================================
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------
//   in        in_valid/in_stall  in_action, in_lookup_key, in_write_value
//   out       out_valid/out_stall out_hit, out_read_value, out_evicted
//   cfg       cfg_valid/cfg_ready cfg_capacity
//
// One word is accepted every cycle while in_stall is low. A word is held in
// the input register; when it advances, the whole store is searched and
// updated in one pass and the result word is registered in the result
// register that drives out_valid. Reset clears the valid marks, ages and
// occupancy at once, with no sweep. A stalled result word holds, and in_stall
// rises when the input register is full and cannot advance.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [KEY_W-1:0] in_lookup_key,
  input  logic [VAL_W-1:0] in_write_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_capacity
);

  localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  // Input register.
  logic             in_valid_r;
  logic             act_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // Result register.
  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_evicted_r;

  // Store.
  logic [MAX_ENTRIES-1:0][KEY_W-1:0] entry_key_r;
  logic [MAX_ENTRIES-1:0][VAL_W-1:0] entry_value_r;
  logic [MAX_ENTRIES-1:0]            entry_valid_r;
  logic [MAX_ENTRIES-1:0][AGE_W-1:0] entry_age_r;
  logic [MAX_ENTRIES-1:0][AGE_W-1:0] entry_age_nxt;
  logic [OCC_W-1:0]                  occ_r;
  logic [CAP_W-1:0]                  cap_r;

  logic                   adv;
  logic                   go;
  logic [MAX_ENTRIES-1:0] match_oh;
  logic [MAX_ENTRIES-1:0] victim_oh;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [MAX_ENTRIES-1:0] slot_oh;
  logic                   hit;
  logic                   insert;
  logic                   evict;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic [VAL_W-1:0]       rd_value;
  lkv_op_t                op;

  assign adv       = !out_valid_r || !out_stall;
  assign go        = in_valid_r && adv;
  assign in_stall  = in_valid_r && !adv;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

  // Capacity zero acts as one; values above the store size saturate.
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > MAX_CMP) begin
      eff_cap = MAX_CMP;
    end else begin
      eff_cap = cap_ext;
    end
  end

  lkv_match #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AGE_W       (AGE_W),
    .OCC_W       (OCC_W)
  ) u_match (
    .key         (key_r),
    .entry_key   (entry_key_r),
    .entry_valid (entry_valid_r),
    .entry_age   (entry_age_r),
    .occupancy   (occ_r),
    .match_oh    (match_oh),
    .victim_oh   (victim_oh),
    .free_oh     (free_oh)
  );

  assign hit     = |match_oh;
  assign insert  = (act_r == ACT_PUT) && !hit;
  assign evict   = insert && (CMP_W'(occ_r) >= eff_cap);
  assign slot_oh = evict ? victim_oh : free_oh;

  assign op.hit    = hit;
  assign op.insert = insert;

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_value = rd_value | (entry_value_r[i] & {VAL_W{match_oh[i]}});
    end
  end

  lkv_ages #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AGE_W       (AGE_W)
  ) u_ages (
    .op          (op),
    .entry_valid (entry_valid_r),
    .entry_age   (entry_age_r),
    .match_oh    (match_oh),
    .slot_oh     (slot_oh),
    .age_nxt     (entry_age_nxt)
  );

  // Handshake and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      entry_age_r   <= '0;
      occ_r         <= '0;
      cap_r         <= CAP_RESET;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (go) begin
        entry_age_r <= entry_age_nxt;
        // An eviction reuses the victim's slot, so the valid marks and the
        // occupancy stay as they are.
        if (insert && !evict) begin
          entry_valid_r <= entry_valid_r | slot_oh;
          occ_r         <= occ_r + OCC_W'(1);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      act_r <= in_action;
      key_r <= in_lookup_key;
      val_r <= in_write_value;
    end
    if (go) begin
      out_hit_r        <= hit;
      out_evicted_r    <= evict;
      out_read_value_r <= (act_r == ACT_GET && hit) ? rd_value : '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (act_r == ACT_PUT && match_oh[i]) begin
          entry_value_r[i] <= val_r;
        end
        if (insert && slot_oh[i]) begin
          entry_key_r[i]   <= key_r;
          entry_value_r[i] <= val_r;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(entry_valid_r) == int'(occ_r))
    else $error("occupancy disagrees with the valid marks");

  a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_read_value_r != '0) |-> out_hit_r)
    else $error("read value without a hit");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> $onehot0(match_oh))
    else $error("key present in more than one entry");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    go && evict |=> $stable(occ_r))
    else $error("occupancy changed on an eviction");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for lru_key_value_cache
// Drives gets and puts through the valid/stall input channel, mirrors the
// cache in a behavioral LRU store to predict every result word, and checks
// each word leaving the result channel in order. Capacity is changed between
// phases while the cache is idle. Both sides idle and stall at random.
// ============================================================================
module testbench;
  import lkv_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int STALL_PERCENT  = 37;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } access_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [KEY_W-1:0] in_lookup_key;
  logic [VAL_W-1:0] in_write_value;
  logic             out_valid;
  logic             out_stall;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             out_evicted;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_capacity;

  // Behavioral copy of the cache contents.
  logic [KEY_W-1:0] mirror_key   [ENTRIES];
  logic [VAL_W-1:0] mirror_value [ENTRIES];
  logic             mirror_live  [ENTRIES];
  int               mirror_age   [ENTRIES];
  int               mirror_fill;
  logic [CAP_W-1:0] mirror_capacity;

  access_result_t   pending_results[$];
  access_result_t   oldest_result;
  logic [KEY_W-1:0] key_pool[$];

  int   fail_count;
  int   quiet_cycles;
  int   holdoff_left;
  logic holdoff_req;
  logic tx_steady;
  logic rx_steady;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one access to the mirror and returns the result word it causes.
  function automatic access_result_t cache_access(logic action, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] value);
    access_result_t res;
    int found;
    int slot;
    int oldest;
    int limit;
    int prev_age;
    res   = '0;
    found = -1;
    slot  = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && mirror_live[i] && mirror_key[i] == key) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (action == ACT_PUT) mirror_value[found] = value;
      else res.read_value = mirror_value[found];
      // Promote to most recent: only entries younger than it grow older.
      prev_age = mirror_age[found];
      for (int i = 0; i < ENTRIES; i++) begin
        if (mirror_live[i] && mirror_age[i] < prev_age) mirror_age[i]++;
      end
      mirror_age[found] = 0;
      return res;
    end
    if (action == ACT_GET) return res;
    if (mirror_capacity == 0) limit = 1;
    else if (mirror_capacity > ENTRIES) limit = ENTRIES;
    else limit = int'(mirror_capacity);
    if (mirror_fill >= limit && mirror_fill > 0) begin
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (mirror_live[i] && (slot < 0 || mirror_age[i] > oldest)) begin
          slot   = i;
          oldest = mirror_age[i];
        end
      end
      if (slot >= 0) begin
        mirror_live[slot] = 1'b0;
        mirror_fill--;
        res.evicted = 1'b1;
      end
    end
    if (slot < 0) begin
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!mirror_live[i]) slot = i;
      end
    end
    if (slot < 0) return res;
    for (int i = 0; i < ENTRIES; i++) begin
      if (mirror_live[i]) mirror_age[i]++;
    end
    mirror_key[slot]   = key;
    mirror_value[slot] = value;
    mirror_live[slot]  = 1'b1;
    mirror_age[slot]   = 0;
    mirror_fill++;
    return res;
  endfunction

  // Offers one word and returns at the edge where it is taken. The valid is
  // left high so the next word can follow back to back.
  task automatic send_access(logic action, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    @(negedge clk);
    while (!tx_steady && $urandom_range(99) < STALL_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= action;
    in_lookup_key  <= key;
    in_write_value <= value;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(cache_access(action, key, value));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] capacity);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= capacity;
    do @(posedge clk); while (!cfg_ready);
    mirror_capacity = capacity;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_key_pool(int count);
    key_pool.delete();
    for (int i = 0; i < count; i++) key_pool.push_back($urandom);
  endtask

  // Mostly keys from the pool so that hits and evictions are common.
  task automatic send_pool_access();
    logic [KEY_W-1:0] key;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(key_pool.size() - 1)];
    else key = $urandom;
    send_access($urandom_range(1) ? ACT_PUT : ACT_GET, key, $urandom);
  endtask

  task automatic test_basic_access();
    send_access(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);   // miss on an empty cache
    send_access(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(ACT_PUT, 32'h0000_0000, 32'h5A5A_A5A5);   // update in place
    send_access(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(ACT_GET, 32'h1234_5678, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_capacity_corners();
    // Zero acts as one; occupancy is already above it, so each new key
    // evicts exactly one entry and occupancy stays put.
    write_capacity(5'd0);
    send_access(ACT_PUT, 32'hA5A5_5A5A, 32'h0000_0001);
    send_access(ACT_PUT, 32'h8000_0001, 32'h0000_0002);
    send_access(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(ACT_GET, 32'h8000_0001, 32'h0000_0000);
    wait_drained();
    // Values above the store size saturate to the full store.
    write_capacity(5'd31);
    send_access(ACT_PUT, 32'h0000_0010, 32'h8000_0000);
    send_access(ACT_PUT, 32'h0000_0020, 32'h7FFF_FFFF);
    send_access(ACT_PUT, 32'h0000_0030, 32'h0000_0003);
    send_access(ACT_GET, 32'h0000_0020, 32'h0000_0000);
    wait_drained();
    write_capacity(5'd1);
    send_access(ACT_PUT, 32'h0000_0040, 32'h0000_0004);
    send_access(ACT_GET, 32'h0000_0010, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_random_phases(int per_phase);
    logic [CAP_W-1:0] plan[10];
    int limit;
    plan = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd31, 5'd17, 5'd8, 5'd0, 5'd3, 5'd12};
    foreach (plan[p]) begin
      write_capacity(plan[p]);
      if (plan[p] == 0) limit = 1;
      else if (plan[p] > ENTRIES) limit = ENTRIES;
      else limit = int'(plan[p]);
      fill_key_pool($urandom_range(limit / 2 + 1, 2 * limit + 2));
      repeat (per_phase) send_pool_access();
      wait_drained();
    end
  endtask

  task automatic test_streaming();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    fill_key_pool(20);
    repeat (60) send_pool_access();
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // The receiver holds off while words keep coming, so the cache must
  // stall its input; then the sender waits for every result.
  task automatic test_backpressure();
    tx_steady   = 1'b1;
    holdoff_req = 1'b1;
    fill_key_pool(10);
    repeat (30) send_pool_access();
    tx_steady = 1'b0;
    wait_drained();
    repeat (20) send_pool_access();
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rx_steady && ($urandom_range(99) < STALL_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no access pending: hit=%0b read_value=%h evicted=%0b",
               out_hit, out_read_value, out_evicted);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_hit !== oldest_result.hit) begin
          $error("hit: expected %0b, got %0b", oldest_result.hit, out_hit);
          fail_count++;
        end
        if (out_read_value !== oldest_result.read_value) begin
          $error("read_value: expected %h, got %h", oldest_result.read_value, out_read_value);
          fail_count++;
        end
        if (out_evicted !== oldest_result.evicted) begin
          $error("evicted: expected %0b, got %0b", oldest_result.evicted, out_evicted);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_GET;
    in_lookup_key   = '0;
    in_write_value  = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_capacity    = CAP_RESET;
    fail_count      = 0;
    quiet_cycles    = 0;
    holdoff_left    = 0;
    holdoff_req     = 1'b0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    mirror_fill     = 0;
    mirror_capacity = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      mirror_key[i]   = '0;
      mirror_value[i] = '0;
      mirror_live[i]  = 1'b0;
      mirror_age[i]   = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_access();
    test_capacity_corners();
    test_streaming();
    test_backpressure();
    test_random_phases(50);

    if (fail_count == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

endmodule
